[design/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg - shared types and constants for the bounded deque
// Operation codes, field widths and the control bundle sent to each cell.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int WORD_W = 32;
	localparam int KIND_W = 3;
	localparam int CAP_W  = 5;

	localparam logic [KIND_W-1:0] KIND_NONE       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd4;

	localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} cell_ctl_t;

endpackage

[design/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell - one slot of the deque chain
// Holds one word and its valid bit; shifts toward either neighbor, takes a
// rear write when it is the first free slot, and drops out on a rear pop.
// ----------------------------------------------------------------------------
module bdq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bdq_pkg::cell_ctl_t ctl,
	input  bdq_pkg::word_t    item_word,
	input  bdq_pkg::word_t    left_word,
	input  logic              left_valid,
	input  bdq_pkg::word_t    right_word,
	input  logic              right_valid,
	output bdq_pkg::word_t    word,
	output logic              valid,
	output bdq_pkg::word_t    rear_word
);
	import bdq_pkg::*;

	word_t word_q;
	logic  valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.push_front) begin
			valid_q <= left_valid;
		end else if (ctl.pop_front) begin
			valid_q <= right_valid;
		end else if (ctl.push_rear) begin
			valid_q <= valid_q | left_valid;
		end else if (ctl.pop_rear) begin
			valid_q <= valid_q & right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			word_q <= left_word;
		end else if (ctl.pop_front) begin
			word_q <= right_word;
		end else if (ctl.push_rear && !valid_q && left_valid) begin
			word_q <= item_word;
		end
	end

	assign word      = word_q;
	assign valid     = valid_q;
	// last occupied slot offers its word to the rear gather
	assign rear_word = (valid_q && !right_valid) ? word_q : '0;

endmodule

[design/bounded_double_ended_queue.sv]
// ----------------------------------------------------------------------------
// bounded_double_ended_queue - bounded deque of signed 32-bit words
// A chain of cells with the front at cell 0; pushes and pops shift the chain.
//
//   channel  direction  handshake           payload
//   cfg      in         cfg_wr_en           cfg_wr_data (capacity in use)
//   in       in         in_valid/in_stall   kind, item_value
//   out      out        out_valid/out_stall success, front_word, rear_word,
//                                           is_empty, is_full
//
// Each item goes through the chain update, then the front/rear gather
// over the cells into the output register.
// The next item is taken once the previous result is registered and is
// not held by out_stall.
// Reset clears the valid bits, the count and the handshake state; capacity
// returns to 16. Cells beyond 31 could never fill, so at most 31 are built.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bdq_pkg::CAP_W-1:0]    cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bdq_pkg::KIND_W-1:0]   kind,
	input  logic signed [bdq_pkg::WORD_W-1:0] item_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         success,
	output logic signed [bdq_pkg::WORD_W-1:0] front_word,
	output logic signed [bdq_pkg::WORD_W-1:0] rear_word,
	output logic                         is_empty,
	output logic                         is_full
);
	import bdq_pkg::*;

	localparam int CAP_MAX = (1 << CAP_W) - 1;
	localparam int USED    = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;
	localparam int CNT_W   = $clog2(USED + 1);

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] cap_eff;
	logic [CNT_W-1:0] count_q;
	logic             pend_q;
	logic             out_valid_q;
	logic             ok_q;
	logic             success_q;
	word_t            front_q;
	word_t            rear_q;
	logic             empty_q;
	logic             full_q;

	logic             in_xfer;
	logic             full_now;
	logic             empty_now;
	logic             ok_now;
	cell_ctl_t        ctl;

	word_t            word_a  [USED];
	logic             valid_a [USED];
	word_t            rear_a  [USED];
	logic [USED-1:0]  valid_vec;
	word_t            rear_or;

	assign in_stall = pend_q | (out_valid_q & out_stall);
	assign in_xfer  = in_valid & ~in_stall;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cap_q > CAP_W'(USED)) begin
			cap_eff = CAP_W'(USED);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign full_now  = CAP_W'(count_q) >= cap_eff;
	assign empty_now = count_q == '0;

	always_comb begin
		ctl    = '0;
		ok_now = 1'b1;
		case (kind)
			KIND_PUSH_FRONT: begin
				ok_now         = ~full_now;
				ctl.push_front = in_xfer & ~full_now;
			end
			KIND_PUSH_REAR: begin
				ok_now        = ~full_now;
				ctl.push_rear = in_xfer & ~full_now;
			end
			KIND_POP_FRONT: begin
				ok_now        = ~empty_now;
				ctl.pop_front = in_xfer & ~empty_now;
			end
			KIND_POP_REAR: begin
				ok_now       = ~empty_now;
				ctl.pop_rear = in_xfer & ~empty_now;
			end
			default: begin
				ok_now = 1'b1;
			end
		endcase
	end

	genvar i;
	generate
		for (i = 0; i < USED; i++) begin : g_cell
			bdq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.item_word   (word_t'(item_value)),
				.left_word   ((i == 0) ? word_t'(item_value) : word_a[(i > 0) ? i - 1 : 0]),
				.left_valid  ((i == 0) ? 1'b1 : valid_a[(i > 0) ? i - 1 : 0]),
				.right_word  ((i == USED - 1) ? word_t'('0) :
				              word_a[(i < USED - 1) ? i + 1 : i]),
				.right_valid ((i == USED - 1) ? 1'b0 :
				              valid_a[(i < USED - 1) ? i + 1 : i]),
				.word        (word_a[i]),
				.valid       (valid_a[i]),
				.rear_word   (rear_a[i])
			);
			assign valid_vec[i] = valid_a[i];
		end
	endgenerate

	always_comb begin
		rear_or = '0;
		for (int k = 0; k < USED; k++) begin
			rear_or = rear_or | rear_a[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(16);
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.push_front || ctl.push_rear) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop_front || ctl.pop_rear) begin
				count_q <= count_q - CNT_W'(1);
			end
			pend_q <= in_xfer;
			if (pend_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ok_q <= ok_now;
		end
		if (pend_q) begin
			success_q <= ok_q;
			empty_q   <= empty_now;
			full_q    <= full_now;
			front_q   <= empty_now ? EMPTY_WORD : word_a[0];
			rear_q    <= empty_now ? EMPTY_WORD : rear_or;
		end
	end

	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign front_word = front_q;
	assign rear_word  = rear_q;
	assign is_empty   = empty_q;
	assign is_full    = full_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(USED))
		else $error("entry count beyond built cells");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("cell valid bits disagree with count");

	a_pend_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !out_valid_q)
		else $error("result pending while previous result still held");

	a_pend_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> out_valid_q)
		else $error("pending result not registered");

endmodule
